### rtl/lsfb_pkg.sv
// ----------------------------------------------------------------------------
// LED strip frame buffer package
// Shared widths, command codes, controller types and the gamma ROM contents.
// ----------------------------------------------------------------------------
package lsfb_pkg;

	localparam int MAX_PIXELS_DEF   = 1024;
	localparam int FOOTER_GROUP_DEF = 64;

	localparam int CMD_W   = 2;
	localparam int INDEX_W = 10;
	localparam int COLOR_W = 8;
	localparam int COUNT_W = 11;
	localparam int WORD_W  = 32;
	localparam int PIXEL_W = 3 * COLOR_W;

	localparam logic [WORD_W-1:0] FRAME_ON = 32'hFF00_0000;
	localparam int unsigned GAMMA_DEN = 130050;
	localparam int unsigned GAMMA_BIAS = 65025;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_PIXEL = 2'd0,
		CMD_SET_ALL   = 2'd1,
		CMD_CLEAR_ALL = 2'd2,
		CMD_FETCH     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL
	} state_t;

	typedef enum logic [1:0] {
		WK_HEADER,
		WK_PIXEL,
		WK_FOOTER
	} word_kind_t;

	typedef struct packed {
		logic wr_en;
		logic wr_from_cnt;
		logic wr_zero;
		logic cnt_clr;
		logic cnt_inc;
		logic load_fill;
		logic fill_zero;
		logic fetch;
	} ctrl_cmd_t;

	typedef struct packed {
		logic idx_ok;
		logic live_zero;
		logic fill_done;
		logic clear_done;
	} dp_status_t;

	typedef logic [255:0][COLOR_W-1:0] gamma_lut_t;

	function automatic gamma_lut_t gamma_init();
		gamma_lut_t lut;
		int unsigned cube;
		for (int i = 0; i < 256; i++) begin
			cube = i * i * i;
			lut[i] = COLOR_W'((2 * cube + GAMMA_BIAS) / GAMMA_DEN);
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = gamma_init();

endpackage

### rtl/lsfb_ctrl.sv
// ----------------------------------------------------------------------------
// LED strip frame buffer controller
// Sequences the power-up clearing pass, single writes, fills and fetches.
// ----------------------------------------------------------------------------
module lsfb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lsfb_pkg::CMD_W-1:0]    command,
	input  lsfb_pkg::dp_status_t          status,
	output lsfb_pkg::ctrl_cmd_t           ctrl,
	output logic                          busy
);
	import lsfb_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		ctrl       = '0;
		busy       = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				ctrl.wr_en       = 1'b1;
				ctrl.wr_from_cnt = 1'b1;
				ctrl.wr_zero     = 1'b1;
				ctrl.cnt_inc     = 1'b1;
				if (status.clear_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_SET_PIXEL: begin
							ctrl.wr_en = status.idx_ok;
						end
						CMD_SET_ALL, CMD_CLEAR_ALL: begin
							ctrl.load_fill = 1'b1;
							ctrl.fill_zero = (command == CMD_CLEAR_ALL);
							ctrl.cnt_clr   = 1'b1;
							if (!status.live_zero) begin
								state_next = ST_FILL;
							end
						end
						CMD_FETCH: begin
							ctrl.fetch = 1'b1;
						end
						default: begin
							ctrl = '0;
						end
					endcase
				end
			end
			ST_FILL: begin
				ctrl.wr_en       = 1'b1;
				ctrl.wr_from_cnt = 1'b1;
				ctrl.cnt_inc     = 1'b1;
				if (status.fill_done) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/lsfb_datapath.sv
// ----------------------------------------------------------------------------
// LED strip frame buffer datapath
// Gamma lookup, pixel store, sweep counter, frame read position and output.
// ----------------------------------------------------------------------------
module lsfb_datapath #(
	parameter int MAX_PIXELS   = lsfb_pkg::MAX_PIXELS_DEF,
	parameter int FOOTER_GROUP = lsfb_pkg::FOOTER_GROUP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsfb_pkg::ctrl_cmd_t            ctrl,
	output lsfb_pkg::dp_status_t           status,
	input  logic [lsfb_pkg::INDEX_W-1:0]   pixel_index,
	input  logic [lsfb_pkg::COLOR_W-1:0]   red,
	input  logic [lsfb_pkg::COLOR_W-1:0]   green,
	input  logic [lsfb_pkg::COLOR_W-1:0]   blue,
	input  logic                           pixel_count_we,
	input  logic [lsfb_pkg::COUNT_W-1:0]   pixel_count,
	output logic                           result_valid,
	output logic [lsfb_pkg::WORD_W-1:0]    frame_word,
	output logic                           last_word
);
	import lsfb_pkg::*;

	localparam int AW       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LIVE_MAX = (MAX_PIXELS < 2047) ? MAX_PIXELS : 2047;
	localparam int MAX_LAST = 1 + LIVE_MAX + LIVE_MAX / FOOTER_GROUP;
	localparam int PW       = $clog2(MAX_LAST + 1);
	localparam int GW       = $clog2(FOOTER_GROUP + 1);
	localparam int PROD_W   = PW + GW;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] live;
	logic [PIXEL_W-1:0] corr;
	logic [PIXEL_W-1:0] fill_q;
	logic [PIXEL_W-1:0] wr_data;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      cnt_q;
	logic [AW-1:0]      rd_addr;
	logic [PIXEL_W-1:0] rd_q;
	logic [PIXEL_W-1:0] mem [MAX_PIXELS];
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      diff;
	logic [PROD_W-1:0]  prod;
	logic               flag;
	word_kind_t         kind;
	word_kind_t         kind_s1;
	logic               last_s1;
	logic               valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (pixel_count_we) begin
			count_q <= pixel_count;
		end
	end

	assign live = (32'(count_q) > MAX_PIXELS) ? COUNT_W'(MAX_PIXELS) : count_q;

	assign corr = {GAMMA_LUT[blue], GAMMA_LUT[green], GAMMA_LUT[red]};

	assign status.idx_ok     = ({1'b0, pixel_index} < live);
	assign status.live_zero  = (live == '0);
	assign status.fill_done  = ((32'(cnt_q) + 32'd1) >= 32'(live));
	assign status.clear_done = (32'(cnt_q) == (MAX_PIXELS - 1));

	always_ff @(posedge clk) begin
		if (ctrl.load_fill) begin
			fill_q <= ctrl.fill_zero ? '0 : corr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign wr_addr = ctrl.wr_from_cnt ? cnt_q : AW'(pixel_index);
	assign wr_data = ctrl.wr_zero ? '0 : (ctrl.wr_from_cnt ? fill_q : corr);
	assign rd_addr = AW'(pos_q - PW'(1));

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign diff = pos_q - PW'(live);
	assign prod = PROD_W'(diff) * PROD_W'(FOOTER_GROUP);
	assign flag = (32'(pos_q) > 32'(live)) && (32'(prod) > 32'(live));

	always_comb begin
		if (pos_q == '0) begin
			kind = WK_HEADER;
		end else if (32'(pos_q) <= 32'(live)) begin
			kind = WK_PIXEL;
		end else begin
			kind = WK_FOOTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.fetch;
			if (ctrl.fetch) begin
				pos_q <= flag ? '0 : pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fetch) begin
			kind_s1 <= kind;
			last_s1 <= flag;
		end
	end

	always_comb begin
		case (kind_s1)
			WK_HEADER: frame_word = '0;
			WK_PIXEL:  frame_word = FRAME_ON | WORD_W'(rd_q);
			default:   frame_word = FRAME_ON;
		endcase
	end

	assign result_valid = valid_s1;
	assign last_word    = last_s1;

endmodule

### rtl/led_strip_frame_buffer.sv
// ----------------------------------------------------------------------------
// LED strip frame buffer
// Gamma-corrected pixel store that serves header, pixel and footer words.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the pixel store and holds
// busy high until the pass is done; pixel_count may be written meanwhile.
// Set pixel and fetch leave busy low, so they may be issued on every cycle.
// A fetched word is shown on frame_word, marked by result_valid for exactly
// one cycle, in the cycle after start was taken.
// Set all and clear all walk the store through its single write port, one
// entry per cycle, and hold busy high until every pixel in use is written.
module led_strip_frame_buffer #(
	parameter int MAX_PIXELS   = lsfb_pkg::MAX_PIXELS_DEF,
	parameter int FOOTER_GROUP = lsfb_pkg::FOOTER_GROUP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lsfb_pkg::CMD_W-1:0]     command,
	input  logic [lsfb_pkg::INDEX_W-1:0]   pixel_index,
	input  logic [lsfb_pkg::COLOR_W-1:0]   red,
	input  logic [lsfb_pkg::COLOR_W-1:0]   green,
	input  logic [lsfb_pkg::COLOR_W-1:0]   blue,
	input  logic                           pixel_count_we,
	input  logic [lsfb_pkg::COUNT_W-1:0]   pixel_count,
	output logic                           result_valid,
	output logic [lsfb_pkg::WORD_W-1:0]    frame_word,
	output logic                           last_word
);
	import lsfb_pkg::*;

	ctrl_cmd_t  ctrl;
	dp_status_t status;

	lsfb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	lsfb_datapath #(
		.MAX_PIXELS   (MAX_PIXELS),
		.FOOTER_GROUP (FOOTER_GROUP)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.pixel_index    (pixel_index),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.pixel_count_we (pixel_count_we),
		.pixel_count    (pixel_count),
		.result_valid   (result_valid),
		.frame_word     (frame_word),
		.last_word      (last_word)
	);

endmodule

### rtl/lsfb_checker.sv
// ----------------------------------------------------------------------------
// LED strip frame buffer checker
// Port-level properties of fetch results and frame boundaries.
// ----------------------------------------------------------------------------
module lsfb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [lsfb_pkg::CMD_W-1:0]     command,
	input logic                           result_valid,
	input logic [lsfb_pkg::WORD_W-1:0]    frame_word,
	input logic                           last_word
);
	import lsfb_pkg::*;

	logic fetch_beat;

	assign fetch_beat = start && !busy && (command == CMD_FETCH);

	a_result_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(fetch_beat))
		else $error("result without a fetch");

	a_fetch_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_beat |=> result_valid)
		else $error("fetch without a result");

	a_last_is_footer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_word |-> frame_word == FRAME_ON)
		else $error("last word is not a footer");

	a_header_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) && $past(last_word) |-> frame_word == '0)
		else $error("frame does not restart with a header");

endmodule

bind led_strip_frame_buffer lsfb_checker u_lsfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.frame_word   (frame_word),
	.last_word    (last_word)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip frame buffer testbench
// Sends pixel writes, fills, clears and frame word fetches under random
// gaps and strip lengths. A software copy of the pixel store and the read
// position predicts every fetched word, and each one is checked on arrival.
// ----------------------------------------------------------------------------
module tb_top;
	import lsfb_pkg::*;

	localparam int STORE_DEPTH = MAX_PIXELS_DEF;
	localparam int GROUP       = FOOTER_GROUP_DEF;
	localparam int SETTLE_CAP  = 4096;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} frame_beat_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [INDEX_W-1:0] pixel_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               pixel_count_we;
	logic [COUNT_W-1:0] pixel_count;
	logic               result_valid;
	logic [WORD_W-1:0]  frame_word;
	logic               last_word;

	logic [PIXEL_W-1:0] shadow_pixels [STORE_DEPTH];
	logic [COLOR_W-1:0] gamma_shadow [256];
	int unsigned        shadow_pos;
	logic [COUNT_W-1:0] shadow_count;
	frame_beat_t        words_due [$];

	int fail_count;
	int sent_count;
	int checked_count;
	int end_count;
	int length_count;
	bit pause_on;

	led_strip_frame_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.pixel_count_we(pixel_count_we),
		.pixel_count(pixel_count),
		.result_valid(result_valid),
		.frame_word(frame_word),
		.last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned live_pixels();
		return (shadow_count > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_count);
	endfunction

	function automatic logic [PIXEL_W-1:0] graded(logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		return {gamma_shadow[b], gamma_shadow[g], gamma_shadow[r]};
	endfunction

	function automatic logic [COLOR_W-1:0] rand_level();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return COLOR_W'($urandom);
		endcase
	endfunction

	task automatic track_command(cmd_t c, logic [INDEX_W-1:0] idx,
			logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		int unsigned n;
		int unsigned final_pos;
		frame_beat_t beat;
		n = live_pixels();
		case (c)
		CMD_SET_PIXEL: begin
			if (idx < n)
				shadow_pixels[idx] = graded(r, g, b);
		end
		CMD_SET_ALL: begin
			for (int i = 0; i < n; i++)
				shadow_pixels[i] = graded(r, g, b);
		end
		CMD_CLEAR_ALL: begin
			for (int i = 0; i < n; i++)
				shadow_pixels[i] = '0;
		end
		default: begin
			final_pos = 1 + n + n / GROUP;
			if (shadow_pos == 0)
				beat.word = '0;
			else if (shadow_pos <= n)
				beat.word = FRAME_ON | shadow_pixels[shadow_pos - 1];
			else
				beat.word = FRAME_ON;
			beat.last = (shadow_pos >= final_pos);
			shadow_pos = beat.last ? 0 : shadow_pos + 1;
			words_due.push_back(beat);
		end
		endcase
	endtask

	task automatic issue(cmd_t c, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		if (pause_on) begin
			while ($urandom_range(0, 99) < 21) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start       <= 1'b1;
		command     <= c;
		pixel_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		do @(posedge clk); while (busy);
		track_command(c, idx, r, g, b);
		sent_count++;
	endtask

	task automatic fetch_words(int n);
		repeat (n)
			issue(CMD_FETCH, INDEX_W'($urandom), rand_level(), rand_level(), rand_level());
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while ((words_due.size() != 0 || busy) && waited < SETTLE_CAP) begin
			@(posedge clk);
			waited++;
		end
		if (words_due.size() != 0) begin
			$error("%0d expected frame words never arrived", words_due.size());
			fail_count++;
			words_due.delete();
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic set_length(logic [COUNT_W-1:0] v);
		settle();
		pixel_count_we <= 1'b1;
		pixel_count    <= v;
		@(posedge clk);
		pixel_count_we <= 1'b0;
		shadow_count = v;
		length_count++;
	endtask

	task automatic random_command();
		int unsigned n;
		int unsigned roll;
		logic [INDEX_W-1:0] idx;
		n = live_pixels();
		roll = $urandom_range(0, 99);
		if (n > 0 && $urandom_range(0, 99) < 75)
			idx = INDEX_W'($urandom_range(0, n - 1));
		else
			idx = INDEX_W'($urandom);
		if (roll < 60)
			issue(CMD_FETCH, idx, rand_level(), rand_level(), rand_level());
		else if (roll < 88)
			issue(CMD_SET_PIXEL, idx, rand_level(), rand_level(), rand_level());
		else if (roll < 94)
			issue(CMD_SET_ALL, idx, rand_level(), rand_level(), rand_level());
		else
			issue(CMD_CLEAR_ALL, idx, rand_level(), rand_level(), rand_level());
	endtask

	task automatic test_reset_state();
		settle();
		fetch_words(3);
	endtask

	task automatic test_directed();
		set_length(3);
		issue(CMD_SET_PIXEL, 0, 8'd0, 8'd0, 8'd0);
		issue(CMD_SET_PIXEL, 2, 8'd255, 8'd255, 8'd255);
		issue(CMD_SET_PIXEL, 1, 8'd1, 8'd128, 8'd254);
		issue(CMD_SET_PIXEL, 3, 8'd9, 8'd9, 8'd9);
		issue(CMD_SET_PIXEL, 10'h3FF, 8'd255, 8'd255, 8'd255);
		fetch_words(5);
		issue(CMD_SET_ALL, 10'h3FF, 8'd17, 8'd170, 8'd85);
		fetch_words(5);
		issue(CMD_CLEAR_ALL, 0, 8'd255, 8'd255, 8'd255);
		fetch_words(5);
	endtask

	task automatic test_count_change();
		set_length(8);
		issue(CMD_SET_ALL, 0, 8'd200, 8'd100, 8'd50);
		set_length(4);
		issue(CMD_CLEAR_ALL, 0, 8'd0, 8'd0, 8'd0);
		set_length(8);
		fetch_words(3);
		issue(CMD_SET_PIXEL, 5, 8'd255, 8'd0, 8'd255);
		fetch_words(8);
		set_length(200);
		fetch_words(120);
		set_length(10);
		fetch_words(3);
		set_length(0);
		fetch_words(3);
	endtask

	task automatic test_full_strip();
		set_length(11'h7FF);
		pause_on = 1'b0;
		issue(CMD_SET_ALL, 0, rand_level(), rand_level(), rand_level());
		issue(CMD_SET_PIXEL, 10'h3FF, 8'd3, 8'd77, 8'd250);
		issue(CMD_SET_PIXEL, 0, 8'd250, 8'd3, 8'd77);
		fetch_words(1 + STORE_DEPTH + STORE_DEPTH / GROUP + 2);
		pause_on = 1'b1;
	endtask

	task automatic test_random();
		int unsigned edges [10] = '{0, 1, 63, 64, 65, 127, 1023, 1024, 1025, 2047};
		for (int phase = 0; phase < 7; phase++) begin
			if ($urandom_range(0, 99) < 80)
				set_length(COUNT_W'($urandom_range(0, 70)));
			else if ($urandom_range(0, 1) == 0)
				set_length(COUNT_W'(edges[$urandom_range(0, 9)]));
			else
				set_length(COUNT_W'($urandom_range(0, 2047)));
			for (int k = 0; k < 90; k++) begin
				// Hold the sender off until every fetched beat is home.
				if (k == 45 && phase == 3)
					settle();
				random_command();
			end
		end
	endtask

	always @(posedge clk) begin : check_beat
		frame_beat_t due;
		if (arst_n && result_valid) begin
			if (words_due.size() == 0) begin
				$error("unexpected frame word %h", frame_word);
				fail_count++;
			end else begin
				due = words_due.pop_front();
				checked_count++;
				if (due.last)
					end_count++;
				if (frame_word !== due.word) begin
					$error("frame_word expected %h actual %h", due.word, frame_word);
					fail_count++;
				end
				if (last_word !== due.last) begin
					$error("last_word expected %b actual %b", due.last, last_word);
					fail_count++;
				end
			end
		end
	end

	initial begin
		start          <= 1'b0;
		command        <= CMD_SET_PIXEL;
		pixel_index    <= '0;
		red            <= '0;
		green          <= '0;
		blue           <= '0;
		pixel_count_we <= 1'b0;
		pixel_count    <= '0;
		arst_n         <= 1'b0;
		pause_on = 1'b1;
		fail_count = 0;
		sent_count = 0;
		checked_count = 0;
		end_count = 0;
		length_count = 0;
		for (int i = 0; i < 256; i++)
			gamma_shadow[i] = COLOR_W'((longint'(i) * i * i + 32512) / 65025);
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_pixels[i] = '0;
		shadow_pos = 0;
		shadow_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed();
		test_count_change();
		test_full_strip();
		test_random();

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d commands across %0d strip length settings.",
			sent_count, length_count);
		$display("Checked %0d frame words, %0d of them closing a frame.",
			checked_count, end_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/lsfb_pkg.sv
rtl/lsfb_ctrl.sv
rtl/lsfb_datapath.sv
rtl/led_strip_frame_buffer.sv
rtl/lsfb_checker.sv
dv/tb_top.sv
